[rtl/bscc_pkg.sv]
// ----------------------------------------------------------------------------
// bscc_pkg
// Shared constants, register indexes, flag struct and arctangent table for
// the blind sector cell classifier.
// ----------------------------------------------------------------------------
package bscc_pkg;

    localparam int BSCC_COORD_BITS   = 24;
    localparam int BSCC_ANGLE_BITS   = 16;
    localparam int BSCC_ANGLE_STAGES = 16;

    localparam int RADIUS_BITS  = 23;
    localparam int SPAN_W       = RADIUS_BITS + 1;
    localparam int PRESHIFT     = 16;
    localparam int XW           = SPAN_W + PRESHIFT + 2;
    localparam int ZW           = 32;
    localparam int SQ_W         = 2 * RADIUS_BITS;
    localparam int CFG_IDX_W    = 3;

    localparam int KEEP_RESET   = 154;
    localparam int CLEAR_RESET  = 2253;
    localparam int MIN_A_RESET  = -20025;
    localparam int MAX_A_RESET  = 20025;

    localparam logic [ZW-1:0] Z_PLUS_QUARTER  = 32'h4000_0000;
    localparam logic [ZW-1:0] Z_MINUS_QUARTER = 32'hC000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd7;

    typedef struct packed {
        logic cand;
        logic zero;
    } t_meta;

    function automatic logic [ZW-1:0] atan_turn(input int unsigned idx);
        logic [ZW-1:0] v;
        case (idx)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051E;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2F;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2FA;
            15:      v = 32'h0000_517D;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A30;
            19:      v = 32'h0000_0518;
            20:      v = 32'h0000_028C;
            21:      v = 32'h0000_0146;
            22:      v = 32'h0000_00A3;
            23:      v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/bscc_front.sv]
// ----------------------------------------------------------------------------
// bscc_front
// Offset from the robot, far test, squared distance window check and the
// quadrant pre-rotation that seeds the arctangent chain. Three stages.
// ----------------------------------------------------------------------------
module bscc_front
    import bscc_pkg::*;
#(
    parameter int COORD_BITS = BSCC_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_robot_x,
    input  logic signed [COORD_BITS-1:0] i_robot_y,
    input  logic        [RADIUS_BITS-1:0] i_keep,
    input  logic        [RADIUS_BITS-1:0] i_clear,
    input  logic                         i_enabled,
    output logic                         o_valid,
    output t_meta                        o_meta,
    output logic signed [XW-1:0]         o_x,
    output logic signed [XW-1:0]         o_y,
    output logic        [ZW-1:0]         o_z
);

    localparam int DW = COORD_BITS + 1;

    logic                   r_va, r_vb, r_vc;
    logic signed [DW-1:0]   r_dx, r_dy;

    logic signed [SPAN_W-1:0]   dxs, dys;
    logic signed [2*SPAN_W-1:0] px, py;
    logic                       far;
    logic signed [XW-1:0]       x0, y0, n_x, n_y;
    logic        [ZW-1:0]       n_z;

    logic        [SQ_W-1:0] r_sqx, r_sqy, r_keep_sq, r_clear_sq;
    logic                   r_far, r_zero, r_en;
    logic signed [XW-1:0]   r_xb, r_yb, r_xc, r_yc;
    logic        [ZW-1:0]   r_zb, r_zc;
    t_meta                  r_meta;
    logic        [SQ_W:0]   sum;

    always_comb begin
        dxs = SPAN_W'(r_dx);
        dys = SPAN_W'(r_dy);
        far = (DW'(dxs) != r_dx) || (DW'(dys) != r_dy)
            || (dxs == {1'b1, {RADIUS_BITS{1'b0}}})
            || (dys == {1'b1, {RADIUS_BITS{1'b0}}});
        px  = (2 * SPAN_W)'(dxs) * (2 * SPAN_W)'(dxs);
        py  = (2 * SPAN_W)'(dys) * (2 * SPAN_W)'(dys);
        x0  = XW'(dxs) <<< PRESHIFT;
        y0  = XW'(dys) <<< PRESHIFT;
        n_x = x0;
        n_y = y0;
        n_z = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                n_x = y0;
                n_y = -x0;
                n_z = Z_PLUS_QUARTER;
            end else begin
                n_x = -y0;
                n_y = x0;
                n_z = Z_MINUS_QUARTER;
            end
        end
        sum = (SQ_W + 1)'(r_sqx) + (SQ_W + 1)'(r_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_adv) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx       <= DW'(i_point_x) - DW'(i_robot_x);
            r_dy       <= DW'(i_point_y) - DW'(i_robot_y);
            r_sqx      <= px[SQ_W-1:0];
            r_sqy      <= py[SQ_W-1:0];
            r_keep_sq  <= SQ_W'(i_keep) * SQ_W'(i_keep);
            r_clear_sq <= SQ_W'(i_clear) * SQ_W'(i_clear);
            r_far      <= far;
            r_zero     <= (r_dx == '0) && (r_dy == '0);
            r_en       <= i_enabled;
            r_xb       <= n_x;
            r_yb       <= n_y;
            r_zb       <= n_z;
            r_meta.cand <= r_en && !r_far && (sum >= (SQ_W + 1)'(r_keep_sq))
                           && (sum <= (SQ_W + 1)'(r_clear_sq));
            r_meta.zero <= r_zero;
            r_xc       <= r_xb;
            r_yc       <= r_yb;
            r_zc       <= r_zb;
        end
    end

    assign o_valid = r_vc;
    assign o_meta  = r_meta;
    assign o_x     = r_xc;
    assign o_y     = r_yc;
    assign o_z     = r_zc;

endmodule

[rtl/bscc_cordic_cell.sv]
// ----------------------------------------------------------------------------
// bscc_cordic_cell
// One vectoring rotation step with a fixed shift; registers the rotated
// vector, the turn accumulator and the item flags for the next cell.
// ----------------------------------------------------------------------------
module bscc_cordic_cell
    import bscc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  t_meta                i_meta,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic        [ZW-1:0] i_z,
    output logic                 o_valid,
    output t_meta                o_meta,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic        [ZW-1:0] o_z
);

    localparam logic [ZW-1:0] ATAN = atan_turn(STAGE);

    logic signed [XW-1:0] xs, ys, n_x, n_y;
    logic        [ZW-1:0] n_z;
    logic                 r_valid;
    t_meta                r_meta;
    logic signed [XW-1:0] r_x, r_y;
    logic        [ZW-1:0] r_z;

    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_y[XW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_meta <= i_meta;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

[rtl/bscc_decide.sv]
// ----------------------------------------------------------------------------
// bscc_decide
// Rounds the turn accumulator to a binary angle, takes it relative to the
// heading and tests it against the visible sector.
// ----------------------------------------------------------------------------
module bscc_decide
    import bscc_pkg::*;
#(
    parameter int ANGLE_BITS = BSCC_ANGLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  t_meta                        i_meta,
    input  logic        [ZW-1:0]         i_z,
    input  logic signed [ANGLE_BITS-1:0] i_heading,
    input  logic signed [ANGLE_BITS-1:0] i_min_angle,
    input  logic signed [ANGLE_BITS-1:0] i_max_angle,
    output logic                         o_valid,
    output logic                         o_hit
);

    localparam logic [ZW-1:0] HALF_LSB = ZW'(1) << (ZW - 1 - ANGLE_BITS);

    logic        [ZW-1:0]         zr;
    logic        [ANGLE_BITS-1:0] raw;
    logic signed [ANGLE_BITS-1:0] rel;
    logic                         r_valid, r_hit;

    always_comb begin
        zr  = i_z + HALF_LSB;
        raw = i_meta.zero ? '0 : zr[ZW-1 -: ANGLE_BITS];
        rel = raw - i_heading;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hit <= i_meta.cand && ((rel < i_min_angle) || (rel > i_max_angle));
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

[rtl/blind_sector_cell_classifier.sv]
// ----------------------------------------------------------------------------
// blind_sector_cell_classifier
// Flags map points that lie in the rear blind zone of the robot: inside the
// distance ring and outside the visible bearing sector.
//
//   channel  direction  handshake              payload
//   in       sink       i_valid / o_stall      i_point_x, i_point_y
//   out      source     o_valid / i_stall      o_clear_cell
//   cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One point per cycle while o_stall is low; the path runs through the three
// front stages, one rotation cell per angle stage, the sector test and the
// output register. Reset clears valid state and loads register defaults.
// Output stall fills a one-beat skid; o_stall rises only while it is full.
// ----------------------------------------------------------------------------
module blind_sector_cell_classifier
    import bscc_pkg::*;
#(
    parameter  int COORD_BITS   = BSCC_COORD_BITS,
    parameter  int ANGLE_BITS   = BSCC_ANGLE_BITS,
    parameter  int ANGLE_STAGES = BSCC_ANGLE_STAGES,
    localparam int CW_R         = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS,
    localparam int CFG_W        = (CW_R > ANGLE_BITS) ? CW_R : ANGLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_clear_cell,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [CFG_W-1:0]      i_cfg_data
);

    logic signed [COORD_BITS-1:0]  r_robot_x, r_robot_y;
    logic signed [ANGLE_BITS-1:0]  r_heading, r_min_angle, r_max_angle;
    logic        [RADIUS_BITS-1:0] r_keep, r_clear;
    logic                          r_enabled;

    logic                 adv, emit, take, hit, last_valid;
    logic                 w_valid [ANGLE_STAGES+1];
    t_meta                w_meta  [ANGLE_STAGES+1];
    logic signed [XW-1:0] w_x     [ANGLE_STAGES+1];
    logic signed [XW-1:0] w_y     [ANGLE_STAGES+1];
    logic        [ZW-1:0] w_z     [ANGLE_STAGES+1];

    logic r_out_valid, r_out, r_skid_valid, r_skid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robot_x   <= '0;
            r_robot_y   <= '0;
            r_heading   <= '0;
            r_keep      <= RADIUS_BITS'(KEEP_RESET);
            r_clear     <= RADIUS_BITS'(CLEAR_RESET);
            r_min_angle <= ANGLE_BITS'(MIN_A_RESET);
            r_max_angle <= ANGLE_BITS'(MAX_A_RESET);
            r_enabled   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROBOT_X:   r_robot_x   <= i_cfg_data[COORD_BITS-1:0];
                CFG_ROBOT_Y:   r_robot_y   <= i_cfg_data[COORD_BITS-1:0];
                CFG_HEADING:   r_heading   <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_KEEP:      r_keep      <= i_cfg_data[RADIUS_BITS-1:0];
                CFG_CLEAR:     r_clear     <= i_cfg_data[RADIUS_BITS-1:0];
                CFG_MIN_ANGLE: r_min_angle <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_MAX_ANGLE: r_max_angle <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_ENABLED:   r_enabled   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign adv     = !r_skid_valid;
    assign o_stall = r_skid_valid;

    bscc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (i_valid),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_robot_x (r_robot_x),
        .i_robot_y (r_robot_y),
        .i_keep    (r_keep),
        .i_clear   (r_clear),
        .i_enabled (r_enabled),
        .o_valid   (w_valid[0]),
        .o_meta    (w_meta[0]),
        .o_x       (w_x[0]),
        .o_y       (w_y[0]),
        .o_z       (w_z[0])
    );

    for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cell
        bscc_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (w_valid[g]),
            .i_meta  (w_meta[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_valid (w_valid[g+1]),
            .o_meta  (w_meta[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    bscc_decide #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (w_valid[ANGLE_STAGES]),
        .i_meta      (w_meta[ANGLE_STAGES]),
        .i_z         (w_z[ANGLE_STAGES]),
        .i_heading   (r_heading),
        .i_min_angle (r_min_angle),
        .i_max_angle (r_max_angle),
        .o_valid     (last_valid),
        .o_hit       (hit)
    );

    assign emit = adv && last_valid;
    assign take = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            r_out_valid  <= r_skid_valid || emit;
            r_skid_valid <= 1'b0;
        end else if (emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_valid ? r_skid : hit;
        end else if (emit) begin
            r_skid <= hit;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_clear_cell = r_out;

endmodule
